// ----- src/wmq_pkg.sv -----
// shared types and constants for the window min/max level quantizer
package wmq_pkg;

	localparam int DEF_WINDOW_DEPTH = 64;
	localparam int DEF_MAX_WIDTH    = 64;

	localparam int DATA_W    = 32;
	localparam int OPC_W     = 2;
	localparam int S_USER_W  = OPC_W + 1;
	localparam int CODE_W    = 4;
	localparam int M_DATA_W  = 8;
	localparam int CFG_W     = 7;
	localparam int REG_IDX_W = 1;

	localparam int QUO_W  = 4;
	localparam int STEP_W = 2;
	localparam int DEN_W  = DATA_W;
	localparam int NUM_W  = DATA_W + QUO_W;

	localparam logic [OPC_W-1:0] OP_APPEND = 2'd0;
	localparam logic [OPC_W-1:0] OP_CLEAR  = 2'd1;
	localparam logic [OPC_W-1:0] OP_RENDER = 2'd2;

	localparam logic [REG_IDX_W-1:0] REG_CAPACITY = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_WIDTH    = 1'b1;

	localparam logic [CODE_W-1:0] BLANK_CODE = 4'd10;
	localparam logic [CODE_W-1:0] LEVEL_ZERO = 4'd0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_PAD,
		ST_RD,
		ST_DAT,
		ST_DIV
	} state_t;

endpackage

// ----- src/wmq_ram.sv -----
// generic single-write, single-read ram with registered read data
module wmq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- src/wmq_div.sv -----
// iterative restoring divider, one quotient bit per cycle
module wmq_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [wmq_pkg::NUM_W-1:0]   num,
	input  logic [wmq_pkg::DEN_W-1:0]   den,
	output logic                        busy,
	output logic [wmq_pkg::QUO_W-1:0]   quo
);
	import wmq_pkg::*;

	logic [NUM_W-1:0]  rem_q;
	logic [NUM_W-1:0]  dsh_q;
	logic [QUO_W-1:0]  quo_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              ge;

	assign ge   = rem_q >= dsh_q;
	assign busy = busy_q;
	assign quo  = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == STEP_W'(QUO_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			dsh_q <= {{(NUM_W - DEN_W - QUO_W + 1){1'b0}}, den, {(QUO_W - 1){1'b0}}};
			quo_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q;
			end
			quo_q <= {quo_q[QUO_W-2:0], ge};
			dsh_q <= dsh_q >> 1;
		end
	end

endmodule

// ----- src/window_minmax_level_quantizer_top.sv -----
// sliding window of Q16.16 samples rendered as min/max-normalized 0..9 level codes
// Appends can arrive back to back while no config write is pending. A render
// with a nonzero width blocks the input until its last code is handed to the output
// register: it scans the whole window through the registered memory read port (no scan
// for an empty window), then emits the blank codes, then for each shown sample does a
// memory read and a division in the four-step shared divider. Output stalls hold the
// render until the output register is free.
module window_minmax_level_quantizer_top #(
	parameter int WINDOW_DEPTH = wmq_pkg::DEF_WINDOW_DEPTH,
	parameter int MAX_WIDTH    = wmq_pkg::DEF_MAX_WIDTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [wmq_pkg::DATA_W-1:0]      s_tdata,   // sample
	input  logic [wmq_pkg::S_USER_W-1:0]    s_tuser,   // opcode, sample_finite
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [wmq_pkg::M_DATA_W-1:0]    m_tdata,   // level_code, zero fill
	output logic                            m_tlast,
	input  logic                            cfg_we,
	input  logic [wmq_pkg::REG_IDX_W-1:0]   cfg_addr,
	input  logic [wmq_pkg::CFG_W-1:0]       cfg_wdata
);
	import wmq_pkg::*;

	localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int CW = $clog2(WINDOW_DEPTH + 1);
	localparam int SW = CW + 1;
	localparam int VW = (CW > CFG_W) ? CW : CFG_W;

	state_t state_q, state_d;

	logic [AW-1:0]     oldest_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     cap_q;
	logic [CW-1:0]     age_q;
	logic [CFG_W-1:0]  width_q;
	logic [CFG_W-1:0]  shown_q;
	logic [CFG_W-1:0]  pad_q;
	logic [DATA_W-1:0] lo_q;
	logic [DATA_W-1:0] hi_q;
	logic              issue_s1;
	logic              first_s1;
	logic              m_valid_q;
	logic [CODE_W-1:0] m_code_q;
	logic              m_last_q;

	logic [OPC_W-1:0]  opcode;
	logic              finite;
	logic              in_acc;
	logic              render_go;
	logic              out_free;

	logic [VW-1:0]     v_ext;
	logic [CW-1:0]     cap_new;
	logic [CFG_W-1:0]  width_new;
	logic              trim;
	logic [CW-1:0]     excess;

	logic [CW-1:0]     age_sel;
	logic [SW-1:0]     sum;
	logic [SW-1:0]     slot_sum;
	logic [AW-1:0]     slot;
	logic [AW-1:0]     oldest_inc;

	logic [CFG_W-1:0]  shown_new;
	logic [CFG_W-1:0]  pad_new;

	logic [DATA_W-1:0] rdata;
	logic [DATA_W:0]   diff;
	logic [DATA_W:0]   span_ext;
	logic [NUM_W-1:0]  num;
	logic              span_zero;
	logic              div_busy;
	logic [QUO_W-1:0]  quo;

	logic              wr_en;
	logic              ram_re;
	logic              emit;
	logic [CODE_W-1:0] emit_code;
	logic              emit_last;
	logic              div_start;

	assign opcode    = s_tuser[OPC_W-1:0];
	assign finite    = s_tuser[OPC_W];
	assign s_tready  = (state_q == ST_IDLE) && !cfg_we;
	assign in_acc    = s_tvalid && s_tready;
	assign render_go = in_acc && (opcode == OP_RENDER) && (width_q != '0);
	assign out_free  = !m_valid_q || m_tready;

	// config decode with saturation
	assign v_ext = VW'(cfg_wdata);
	always_comb begin
		if (cfg_wdata == '0) begin
			cap_new = CW'(1);
		end else if (v_ext > VW'(WINDOW_DEPTH)) begin
			cap_new = CW'(WINDOW_DEPTH);
		end else begin
			cap_new = CW'(v_ext);
		end
	end
	assign width_new = (cfg_wdata > CFG_W'(MAX_WIDTH)) ? CFG_W'(MAX_WIDTH) : cfg_wdata;
	assign trim      = cfg_we && (cfg_addr == REG_CAPACITY) && (count_q > cap_new);
	assign excess    = count_q - cap_new;

	// circular slot of an age
	assign age_sel  = (state_q == ST_IDLE) ? (cfg_we ? excess : count_q) : age_q;
	assign sum      = SW'(oldest_q) + SW'(age_sel);
	assign slot_sum = (sum >= SW'(WINDOW_DEPTH)) ? sum - SW'(WINDOW_DEPTH) : sum;
	assign slot     = slot_sum[AW-1:0];
	assign oldest_inc = (oldest_q == AW'(WINDOW_DEPTH - 1)) ? '0 : oldest_q + 1'b1;

	assign shown_new = (VW'(count_q) < VW'(width_q)) ? CFG_W'(count_q) : width_q;
	assign pad_new   = width_q - shown_new;

	// divider operands
	assign diff      = {rdata[DATA_W-1], rdata} - {lo_q[DATA_W-1], lo_q};
	assign span_ext  = {hi_q[DATA_W-1], hi_q} - {lo_q[DATA_W-1], lo_q};
	assign num       = {{QUO_W{1'b0}}, diff[DATA_W-1:0]} +
	                   {1'b0, diff[DATA_W-1:0], 3'b000};
	assign span_zero = hi_q == lo_q;

	wmq_ram #(
		.WIDTH (DATA_W),
		.DEPTH (WINDOW_DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (slot),
		.wdata (s_tdata),
		.re    (ram_re),
		.raddr (slot),
		.rdata (rdata)
	);

	wmq_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num),
		.den    (span_ext[DATA_W-1:0]),
		.busy   (div_busy),
		.quo    (quo)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (render_go) begin
					state_d = (count_q != '0) ? ST_SCAN : ST_PAD;
				end
			end
			ST_SCAN: begin
				if ((age_q == count_q) && !issue_s1) begin
					state_d = ST_PAD;
				end
			end
			ST_PAD: begin
				if (pad_q == '0) begin
					state_d = ST_RD;
				end else if (out_free && (pad_q == CFG_W'(1)) && (shown_q == '0)) begin
					state_d = ST_IDLE;
				end
			end
			ST_RD: begin
				state_d = ST_DAT;
			end
			ST_DAT: begin
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (!div_busy && out_free) begin
					state_d = (shown_q == CFG_W'(1)) ? ST_IDLE : ST_RD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		wr_en     = 1'b0;
		ram_re    = 1'b0;
		emit      = 1'b0;
		emit_code = BLANK_CODE;
		emit_last = 1'b0;
		div_start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				wr_en = in_acc && (opcode == OP_APPEND) && finite;
			end
			ST_SCAN: begin
				ram_re = age_q < count_q;
			end
			ST_PAD: begin
				if ((pad_q != '0) && out_free) begin
					emit      = 1'b1;
					emit_last = (pad_q == CFG_W'(1)) && (shown_q == '0);
				end
			end
			ST_RD: begin
				ram_re = 1'b1;
			end
			ST_DAT: begin
				div_start = 1'b1;
			end
			ST_DIV: begin
				if (!div_busy && out_free) begin
					emit      = 1'b1;
					emit_code = span_zero ? LEVEL_ZERO : quo;
					emit_last = shown_q == CFG_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			oldest_q  <= '0;
			count_q   <= '0;
			cap_q     <= CW'(WINDOW_DEPTH);
			width_q   <= CFG_W'(MAX_WIDTH);
			age_q     <= '0;
			shown_q   <= '0;
			pad_q     <= '0;
			issue_s1  <= 1'b0;
			first_s1  <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			issue_s1 <= ram_re && (state_q == ST_SCAN);
			first_s1 <= age_q == '0;

			if (cfg_we) begin
				case (cfg_addr)
					REG_CAPACITY: begin
						cap_q <= cap_new;
						if (trim) begin
							oldest_q <= slot;
							count_q  <= cap_new;
						end
					end
					REG_WIDTH: begin
						width_q <= width_new;
					end
					default: begin
					end
				endcase
			end

			if (in_acc) begin
				case (opcode)
					OP_APPEND: begin
						if (finite) begin
							if (count_q >= cap_q) begin
								oldest_q <= oldest_inc;
							end else begin
								count_q <= count_q + 1'b1;
							end
						end
					end
					OP_CLEAR: begin
						count_q  <= '0;
						oldest_q <= '0;
					end
					OP_RENDER: begin
						age_q   <= '0;
						shown_q <= shown_new;
						pad_q   <= pad_new;
					end
					default: begin
					end
				endcase
			end

			if ((state_q == ST_SCAN) && ram_re) begin
				age_q <= age_q + 1'b1;
			end
			if ((state_q == ST_SCAN) && (state_d == ST_PAD)) begin
				age_q <= count_q - CW'(shown_q);
			end
			if ((state_q == ST_PAD) && emit) begin
				pad_q <= pad_q - 1'b1;
			end
			if ((state_q == ST_DIV) && emit) begin
				shown_q <= shown_q - 1'b1;
				age_q   <= age_q + 1'b1;
			end

			if (emit) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// window min/max and output beat payload
	always_ff @(posedge clk) begin
		if (issue_s1) begin
			if (first_s1) begin
				lo_q <= rdata;
				hi_q <= rdata;
			end else begin
				if ($signed(rdata) < $signed(lo_q)) begin
					lo_q <= rdata;
				end
				if ($signed(rdata) > $signed(hi_q)) begin
					hi_q <= rdata;
				end
			end
		end
		if (emit) begin
			m_code_q <= emit_code;
			m_last_q <= emit_last;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(M_DATA_W - CODE_W){1'b0}}, m_code_q};
	assign m_tlast  = m_last_q;

endmodule
